FILE: rtl/rti_pkg.sv
package rti_pkg;

  localparam int FIELD_W = 32;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ORIGIN_X = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y = 3'd1;
  localparam cfg_idx_t CFG_ORIGIN_Z = 3'd2;
  localparam cfg_idx_t CFG_TARGET_X = 3'd3;
  localparam cfg_idx_t CFG_TARGET_Y = 3'd4;
  localparam cfg_idx_t CFG_TARGET_Z = 3'd5;
  localparam cfg_idx_t CFG_PAR_THR  = 3'd6;

  typedef enum logic [2:0] {
    MISS_NONE     = 3'd0,
    MISS_PARALLEL = 3'd1,
    MISS_U        = 3'd2,
    MISS_V        = 3'd3,
    MISS_T        = 3'd4
  } miss_reason_t;

endpackage

FILE: rtl/rti_in_if.sv
interface rti_in_if
  import rti_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] vert_a_x;
  logic [FIELD_W-1:0] vert_a_y;
  logic [FIELD_W-1:0] vert_a_z;
  logic [FIELD_W-1:0] vert_b_x;
  logic [FIELD_W-1:0] vert_b_y;
  logic [FIELD_W-1:0] vert_b_z;
  logic [FIELD_W-1:0] vert_c_x;
  logic [FIELD_W-1:0] vert_c_y;
  logic [FIELD_W-1:0] vert_c_z;

  modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                  vert_c_x, vert_c_y, vert_c_z, input ready);
  modport sink (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
                vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

FILE: rtl/rti_out_if.sv
interface rti_out_if
  import rti_pkg::*;
();
  logic         valid;
  logic         ready;
  logic         hit;
  miss_reason_t miss_reason;

  modport source (output valid, hit, miss_reason, input ready);
  modport sink (input valid, hit, miss_reason, output ready);
endinterface

FILE: rtl/rti_cfg_if.sv
interface rti_cfg_if
  import rti_pkg::*;
();
  logic               valid;
  logic               ready;
  cfg_idx_t           index;
  logic [FIELD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ray_triangle_intersect.sv
// Ray segment / triangle intersection, division-free Moller-Trumbore.
// cfg_ch: register writes (origin xyz, target xyz, parallel threshold),
//   always ready; write only while no triangle is in flight.
// in_ch: one word per triangle, three signed Q23.8 vertices.
// out_ch: one word per triangle, hit flag and miss reason.
// Coordinates use the low COORD_BITS bits of each field, sign extended.
// Throughput: one triangle per cycle while the receiver holds out_ch.ready
//   high; eight register stages, the first loaded at the accepting edge
//   (differences, cross products, cross sums, split dot multiplies, product
//   merge, dot sums, sign fix, compare).
// Each stage has its own valid bit and advances when the next stage is
//   empty or advancing, so a stalled receiver fills bubbles first and
//   in_ch.ready drops only when every stage holds a word; nothing is lost
//   or repeated.
// Reset clears all valid bits and the configuration registers to zero.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  rti_in_if.sink   in_ch,
  rti_out_if.source out_ch,
  rti_cfg_if.sink  cfg_ch
);

  localparam int D    = COORD_BITS + 1;
  localparam int P    = 2 * D;
  localparam int X    = P + 1;
  localparam int LO_W = (X + 1) / 2;
  localparam int FW   = D + X;
  localparam int SW   = FW + 2;
  localparam int NS   = 8;

  logic [FIELD_W-1:0] org_x_r, org_y_r, org_z_r;
  logic [FIELD_W-1:0] tgt_x_r, tgt_y_r, tgt_z_r;
  logic [FIELD_W-1:0] thr_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; org_z_r <= '0;
      tgt_x_r <= '0; tgt_y_r <= '0; tgt_z_r <= '0;
      thr_r   <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ORIGIN_X: org_x_r <= cfg_ch.data;
        CFG_ORIGIN_Y: org_y_r <= cfg_ch.data;
        CFG_ORIGIN_Z: org_z_r <= cfg_ch.data;
        CFG_TARGET_X: tgt_x_r <= cfg_ch.data;
        CFG_TARGET_Y: tgt_y_r <= cfg_ch.data;
        CFG_TARGET_Z: tgt_z_r <= cfg_ch.data;
        CFG_PAR_THR:  thr_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stage control
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: differences
  logic signed [D-1:0] o_c [3], t_c [3], a_c [3], b_c [3], c_c [3];
  logic signed [D-1:0] dir_nxt [3], e1_nxt [3], e2_nxt [3], s_nxt [3];
  logic signed [D-1:0] dir1_r [3], e11_r [3], e21_r [3], s1_r [3];

  always_comb begin
    o_c[0] = D'($signed(org_x_r[COORD_BITS-1:0]));
    o_c[1] = D'($signed(org_y_r[COORD_BITS-1:0]));
    o_c[2] = D'($signed(org_z_r[COORD_BITS-1:0]));
    t_c[0] = D'($signed(tgt_x_r[COORD_BITS-1:0]));
    t_c[1] = D'($signed(tgt_y_r[COORD_BITS-1:0]));
    t_c[2] = D'($signed(tgt_z_r[COORD_BITS-1:0]));
    a_c[0] = D'($signed(in_ch.vert_a_x[COORD_BITS-1:0]));
    a_c[1] = D'($signed(in_ch.vert_a_y[COORD_BITS-1:0]));
    a_c[2] = D'($signed(in_ch.vert_a_z[COORD_BITS-1:0]));
    b_c[0] = D'($signed(in_ch.vert_b_x[COORD_BITS-1:0]));
    b_c[1] = D'($signed(in_ch.vert_b_y[COORD_BITS-1:0]));
    b_c[2] = D'($signed(in_ch.vert_b_z[COORD_BITS-1:0]));
    c_c[0] = D'($signed(in_ch.vert_c_x[COORD_BITS-1:0]));
    c_c[1] = D'($signed(in_ch.vert_c_y[COORD_BITS-1:0]));
    c_c[2] = D'($signed(in_ch.vert_c_z[COORD_BITS-1:0]));
    for (int i = 0; i < 3; i++) begin
      dir_nxt[i] = t_c[i] - o_c[i];
      e1_nxt[i]  = b_c[i] - a_c[i];
      e2_nxt[i]  = c_c[i] - a_c[i];
      s_nxt[i]   = o_c[i] - a_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dir1_r <= dir_nxt;
      e11_r  <= e1_nxt;
      e21_r  <= e2_nxt;
      s1_r   <= s_nxt;
    end
  end

  // stage 2: cross products, h = dir x e2 in pm[0..5], q = s x e1 in pm[6..11]
  logic signed [P-1:0] pm_nxt [12];
  logic signed [P-1:0] pm2_r [12];
  logic signed [D-1:0] dir2_r [3], e12_r [3], e22_r [3], s2_r [3];

  always_comb begin
    pm_nxt[0]  = P'(dir1_r[1]) * P'(e21_r[2]);
    pm_nxt[1]  = P'(dir1_r[2]) * P'(e21_r[1]);
    pm_nxt[2]  = P'(dir1_r[2]) * P'(e21_r[0]);
    pm_nxt[3]  = P'(dir1_r[0]) * P'(e21_r[2]);
    pm_nxt[4]  = P'(dir1_r[0]) * P'(e21_r[1]);
    pm_nxt[5]  = P'(dir1_r[1]) * P'(e21_r[0]);
    pm_nxt[6]  = P'(s1_r[1]) * P'(e11_r[2]);
    pm_nxt[7]  = P'(s1_r[2]) * P'(e11_r[1]);
    pm_nxt[8]  = P'(s1_r[2]) * P'(e11_r[0]);
    pm_nxt[9]  = P'(s1_r[0]) * P'(e11_r[2]);
    pm_nxt[10] = P'(s1_r[0]) * P'(e11_r[1]);
    pm_nxt[11] = P'(s1_r[1]) * P'(e11_r[0]);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pm2_r  <= pm_nxt;
      dir2_r <= dir1_r;
      e12_r  <= e11_r;
      e22_r  <= e21_r;
      s2_r   <= s1_r;
    end
  end

  // stage 3: cross sums
  logic signed [X-1:0] h3_r [3], q3_r [3];
  logic signed [D-1:0] dir3_r [3], e13_r [3], e23_r [3], s3_r [3];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        h3_r[i] <= X'(pm2_r[2*i]) - X'(pm2_r[2*i+1]);
        q3_r[i] <= X'(pm2_r[6+2*i]) - X'(pm2_r[6+2*i+1]);
      end
      dir3_r <= dir2_r;
      e13_r  <= e12_r;
      e23_r  <= e22_r;
      s3_r   <= s2_r;
    end
  end

  // stage 4: dot product terms; det, us, vs, ts in groups of three
  logic signed [D-1:0]      ma [12];
  logic signed [X-1:0]      mb [12];
  logic signed [D+LO_W:0]   plo [12];
  logic signed [FW-LO_W-1:0] phi [12];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i]   = e13_r[i];  mb[i]   = h3_r[i];
      ma[3+i] = s3_r[i];   mb[3+i] = h3_r[i];
      ma[6+i] = dir3_r[i]; mb[6+i] = q3_r[i];
      ma[9+i] = e23_r[i];  mb[9+i] = q3_r[i];
    end
  end

  for (genvar j = 0; j < 12; j++) begin : g_mul
    rti_split_mul #(
      .A_W  (D),
      .B_W  (X),
      .LO_W (LO_W)
    ) u_mul (
      .clk    (clk),
      .en     (adv[3]),
      .a      (ma[j]),
      .b      (mb[j]),
      .p_lo_r (plo[j]),
      .p_hi_r (phi[j])
    );
  end

  // stage 5: merge partial products
  logic signed [FW-1:0] fp5_r [12];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int j = 0; j < 12; j++) begin
        fp5_r[j] <= (FW'(phi[j]) <<< LO_W) + FW'(plo[j]);
      end
    end
  end

  // stage 6: dot sums
  logic signed [SW-1:0] dot6_r [4];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int g = 0; g < 4; g++) begin
        dot6_r[g] <= SW'(fp5_r[3*g]) + SW'(fp5_r[3*g+1]) + SW'(fp5_r[3*g+2]);
      end
    end
  end

  // stage 7: scale by sign of det
  logic signed [SW-1:0] mag7_r, us7_r, vs7_r, ts7_r;
  logic                 neg6;

  assign neg6 = dot6_r[0][SW-1];

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      mag7_r <= neg6 ? -dot6_r[0] : dot6_r[0];
      us7_r  <= neg6 ? -dot6_r[1] : dot6_r[1];
      vs7_r  <= neg6 ? -dot6_r[2] : dot6_r[2];
      ts7_r  <= neg6 ? -dot6_r[3] : dot6_r[3];
    end
  end

  // stage 8: bound tests
  logic signed [SW:0]   uvs;
  logic signed [SW-1:0] thr_ext;
  miss_reason_t         reason_nxt;
  miss_reason_t         reason8_r;

  always_comb begin
    uvs     = (SW+1)'(us7_r) + (SW+1)'(vs7_r);
    thr_ext = $signed({{(SW-FIELD_W){1'b0}}, thr_r});
    if (!(thr_ext < mag7_r)) begin
      reason_nxt = MISS_PARALLEL;
    end else if (us7_r[SW-1] || (mag7_r < us7_r)) begin
      reason_nxt = MISS_U;
    end else if (vs7_r[SW-1] || ((SW+1)'(mag7_r) < uvs)) begin
      reason_nxt = MISS_V;
    end else if (ts7_r[SW-1] || (ts7_r == '0) || !(ts7_r < mag7_r)) begin
      reason_nxt = MISS_T;
    end else begin
      reason_nxt = MISS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      reason8_r <= reason_nxt;
    end
  end

  assign out_ch.valid       = v_r[NS-1];
  assign out_ch.miss_reason = reason8_r;
  assign out_ch.hit         = (reason8_r == MISS_NONE);

endmodule

FILE: rtl/rti_split_mul.sv
module rti_split_mul #(
  parameter int A_W  = 33,
  parameter int B_W  = 67,
  parameter int LO_W = 34
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [A_W-1:0]          a,
  input  logic signed [B_W-1:0]          b,
  output logic signed [A_W+LO_W:0]       p_lo_r,
  output logic signed [A_W+B_W-LO_W-1:0] p_hi_r
);

  logic signed [LO_W:0]       lo;
  logic signed [B_W-LO_W-1:0] hi;

  assign lo = $signed({1'b0, b[LO_W-1:0]});
  assign hi = b[B_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= a * lo;
      p_hi_r <= a * hi;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench
  import rti_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] c[9];
  } tri_t;

  typedef struct {
    logic         hit;
    miss_reason_t reason;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rti_in_if  in_ch ();
  rti_out_if out_ch ();
  rti_cfg_if cfg_ch ();

  ray_triangle_intersect dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] seg_reg[7];
  verdict_t    verdicts_due[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic logic signed [127:0] sx(logic [31:0] v);
    return 128'(signed'(v));
  endfunction

  function automatic verdict_t judge_triangle(tri_t t);
    logic signed [127:0] o[3], d[3], e1[3], e2[3], s[3], h[3], q[3];
    logic signed [127:0] det, mag, us, vs, ts, thr;
    verdict_t r;
    for (int i = 0; i < 3; i++) begin
      o[i] = sx(seg_reg[i]);
      d[i] = sx(seg_reg[3 + i]) - o[i];
      e1[i] = sx(t.c[3 + i]) - sx(t.c[i]);
      e2[i] = sx(t.c[6 + i]) - sx(t.c[i]);
      s[i] = o[i] - sx(t.c[i]);
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    us = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vs = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    ts = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    mag = det;
    if (det < 0) begin
      mag = -det; us = -us; vs = -vs; ts = -ts;
    end
    thr = $signed({96'd0, seg_reg[6]});
    if (!(thr < mag)) r.reason = MISS_PARALLEL;
    else if (us < 0 || us > mag) r.reason = MISS_U;
    else if (vs < 0 || us + vs > mag) r.reason = MISS_V;
    else if (ts <= 0 || ts >= mag) r.reason = MISS_T;
    else r.reason = MISS_NONE;
    r.hit = (r.reason == MISS_NONE);
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ORIGIN_X;
    cfg_ch.data = '0;
    {in_ch.vert_a_x, in_ch.vert_a_y, in_ch.vert_a_z} = '0;
    {in_ch.vert_b_x, in_ch.vert_b_y, in_ch.vert_b_z} = '0;
    {in_ch.vert_c_x, in_ch.vert_c_y, in_ch.vert_c_z} = '0;
    for (int i = 0; i < 7; i++) seg_reg[i] = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        exp_v = verdicts_due.pop_front();
        if (out_ch.hit !== exp_v.hit || out_ch.miss_reason !== exp_v.reason) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: hit %0b/%0b reason %0d/%0d (exp/act)",
                     exp_v.hit, out_ch.hit, exp_v.reason, out_ch.miss_reason);
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx <= CFG_PAR_THR) seg_reg[idx] = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_segment(logic [31:0] ox, oy, oz, tx, ty, tz, thr);
    drain();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_TARGET_X, tx);
    write_reg(CFG_TARGET_Y, ty);
    write_reg(CFG_TARGET_Z, tz);
    write_reg(CFG_PAR_THR, thr);
  endtask

  task automatic send_triangle(tri_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.vert_a_x, in_ch.vert_a_y, in_ch.vert_a_z} <= {t.c[0], t.c[1], t.c[2]};
    {in_ch.vert_b_x, in_ch.vert_b_y, in_ch.vert_b_z} <= {t.c[3], t.c[4], t.c[5]};
    {in_ch.vert_c_x, in_ch.vert_c_y, in_ch.vert_c_z} <= {t.c[6], t.c[7], t.c[8]};
    do @(posedge clk); while (!in_ch.ready);
    verdicts_due.push_back(judge_triangle(t));
  endtask

  task automatic release_input;
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(4096)) - 2048);
      default: return 32'($signed($urandom_range(1 << 16)) - (1 << 15)) <<< 4;
    endcase
  endfunction

  // triangle, on about half the calls built around the segment midpoint so u, v, t land near the bounds
  function automatic tri_t aimed_triangle();
    tri_t t;
    int m;
    m = $urandom_range(2, 1);
    for (int i = 0; i < 9; i++) t.c[i] = rand_coord(m);
    if ($urandom_range(1)) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [31:0] mid;
        mid = (signed'(seg_reg[i]) >>> 1) + (signed'(seg_reg[3 + i]) >>> 1);
        t.c[i] = mid + signed'(32'($signed($urandom_range(4000)) - 2000));
        t.c[3 + i] = mid + signed'(32'($signed($urandom_range(4000)) - 2000));
        t.c[6 + i] = mid + signed'(32'($signed($urandom_range(4000)) - 2000));
      end
    end
    return t;
  endfunction

  task automatic test_directed;
    tri_t t;
    set_segment(32'h0, 32'h0, -32'sd2560, 32'h0, 32'h0, 32'sd2560, 32'd0);
    t.c = '{-32'sd2560, -32'sd2560, 0, 32'sd2560, -32'sd2560, 0, 0, 32'sd2560, 0};
    send_triangle(t);
    t.c = '{-32'sd2560, -32'sd2560, 0, 32'sd2560, -32'sd2560, 0, -32'sd2560, -32'sd2560, 0};
    send_triangle(t);
    t.c = '{32'sd256, -32'sd2560, 0, 32'sd2560, -32'sd2560, 0, 32'sd2560, 32'sd2560, 0};
    send_triangle(t);
    t.c = '{-32'sd2560, 32'sd256, 0, 32'sd2560, 32'sd256, 0, 32'sd2560, 32'sd2560, 0};
    send_triangle(t);
    t.c = '{-32'sd2560, -32'sd2560, 32'sd5000, 32'sd2560, -32'sd2560, 32'sd5000,
            0, 32'sd2560, 32'sd5000};
    send_triangle(t);
    t.c = '{-32'sd2560, -32'sd2560, 32'sd2560, 32'sd2560, -32'sd2560, 32'sd2560,
            0, 32'sd2560, 32'sd2560};
    send_triangle(t);
    t.c = '{0, 0, 0, 32'sd2560, 0, 0, 0, 32'sd2560, 0};
    send_triangle(t);
    t.c = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'hffffffff, 32'h0, 32'h80000000};
    send_triangle(t);
    t.c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0};
    send_triangle(t);
    release_input();
    set_segment(32'h0, 32'h0, -32'sd2560, 32'h0, 32'h0, 32'sd2560, 32'hffffffff);
    t.c = '{-32'sd2560, -32'sd2560, 0, 32'sd2560, -32'sd2560, 0, 0, 32'sd2560, 0};
    send_triangle(t);
    release_input();
    set_segment(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'd1);
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 9; k++) t.c[k] = rand_coord(0);
      send_triangle(t);
    end
    release_input();
  endtask

  task automatic test_random(int n, int idle, int stall);
    tri_t t;
    logic [31:0] thr;
    int m;
    m = $urandom_range(2);
    thr = (m == 0) ? $urandom() : $urandom_range(m == 1 ? 0 : 65535);
    drain();
    send_idle_pct = idle;
    recv_stall_pct = stall;
    set_segment(rand_coord(m), rand_coord(m), rand_coord(m),
                rand_coord(m), rand_coord(m), rand_coord(m), thr);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) for (int k = 0; k < 9; k++) t.c[k] = $urandom();
      else t = aimed_triangle();
      send_triangle(t);
      if ($urandom_range(15) == 0) release_input();
    end
    release_input();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    for (int r = 0; r < 4; r++) begin
      test_random(40, 0, 0);
      test_random(40, 83, 0);
      test_random(40, 0, 83);
      test_random(40, 19, 19);
    end
    drain();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

FILE: sim.f
rtl/rti_pkg.sv
rtl/rti_in_if.sv
rtl/rti_out_if.sv
rtl/rti_cfg_if.sv
rtl/rti_split_mul.sv
rtl/ray_triangle_intersect.sv
tb/sv/testbench.sv
